// File: hw/rtl/bffa_pkg.sv
// Package for the bitmap first-fit allocator: sizes, status codes, the request
// kind codes, the map access struct and the first-clear-bit search.
// No dependencies.
`timescale 1ns / 1ps

package bffa_pkg;

   localparam int MAP_WORDS   = 32;
   localparam int WORD_W      = 32;
   localparam int WORD_AW     = $clog2(MAP_WORDS);
   localparam int BIT_AW      = $clog2(WORD_W);
   localparam int IDX_W       = 10;
   localparam int CFG_W       = 6;
   localparam int WORDS_RESET = 32;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef struct packed {
      logic               rd_en;
      logic [WORD_AW-1:0] rd_addr;
      logic               wr_en;
      logic [WORD_AW-1:0] wr_addr;
      logic [WORD_W-1:0]  wr_data;
   } map_req_type;

   // Position of the lowest clear bit; only meaningful when one exists.
   function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_W-1:0] word);
      logic [BIT_AW-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = BIT_AW'(i);
         end
      end
      return pos;
   endfunction

endpackage

// File: hw/rtl/bffa_if.sv
// Channel interfaces of the bitmap first-fit allocator: request, response
// and register write. Depends on bffa_pkg.
`timescale 1ns / 1ps

interface bffa_req_if
   import bffa_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [IDX_W-1:0] position;

   modport source (output valid, kind, position, input ready);
   modport sink (input valid, kind, position, output ready);
endinterface

interface bffa_rsp_if
   import bffa_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [IDX_W-1:0] entry_index;

   modport source (output valid, status, entry_index, input ready);
   modport sink (input valid, status, entry_index, output ready);
endinterface

interface bffa_csr_if
   import bffa_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/bffa_map.sv
// Allocation map storage: one-port-read, one-port-write word memory with a
// registered read and a valid bit per word so that reset reads as all free.
// Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_map
   import bffa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  map_req_type       map_req,
   output logic [WORD_W-1:0] rd_word
);

   logic [WORD_W-1:0]    mem_ff [MAP_WORDS];
   logic [MAP_WORDS-1:0] valid_ff;
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= mem_ff[map_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (map_req.wr_en) begin
            valid_ff[map_req.wr_addr] <= 1'b1;
         end
         if (map_req.rd_en) begin
            rd_vld_ff <= valid_ff[map_req.rd_addr];
         end
      end
   end

   // A word never written since reset is all free.
   assign rd_word = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: hw/rtl/bffa_ctrl.sv
// Sequencer of the allocator: scans map words one per cycle for allocates,
// does the read-modify-write of frees and holds the response register.
// Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_ctrl
   import bffa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CFG_W-1:0]  limit,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [IDX_W-1:0]  req_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [IDX_W-1:0]  rsp_entry_index,
   output map_req_type       map_req,
   input  logic [WORD_W-1:0] rd_word
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [WORD_AW-1:0] addr_ff, addr_in;
   logic [BIT_AW-1:0]  bit_ff, bit_in;
   status_type         res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_index_ff, res_index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;

   logic [BIT_AW-1:0]  zero_pos;
   logic [CFG_W-1:0]   next_count;
   logic [WORD_AW-1:0] free_word;

   assign zero_pos   = first_zero(rd_word);
   assign next_count = CFG_W'(addr_ff) + CFG_W'(1);
   assign free_word  = req_position[IDX_W-1:BIT_AW];

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      map_req       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_ALLOC) begin
                  if (limit == '0) begin
                     res_status_in = ST_FULL;
                     res_index_in  = '0;
                     state_in      = S_FINISH;
                  end else begin
                     addr_in         = '0;
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = '0;
                     state_in        = S_SCAN;
                  end
               end else begin
                  if (CFG_W'(free_word) < limit) begin
                     addr_in         = free_word;
                     bit_in          = req_position[BIT_AW-1:0];
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = free_word;
                     state_in        = S_FREE;
                  end else begin
                     res_status_in = ST_RANGE;
                     res_index_in  = '0;
                     state_in      = S_FINISH;
                  end
               end
            end
         end
         S_SCAN: begin
            if (rd_word != '1) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = addr_ff;
               map_req.wr_data = rd_word | (WORD_W'(1) << zero_pos);
               res_status_in   = ST_DONE;
               res_index_in    = IDX_W'({addr_ff, zero_pos});
               state_in        = S_FINISH;
            end else if (next_count >= limit) begin
               res_status_in = ST_FULL;
               res_index_in  = '0;
               state_in      = S_FINISH;
            end else begin
               addr_in         = addr_ff + WORD_AW'(1);
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = addr_ff + WORD_AW'(1);
            end
         end
         S_FREE: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = addr_ff;
            map_req.wr_data = rd_word & ~(WORD_W'(1) << bit_ff);
            res_status_in   = ST_DONE;
            res_index_in    = IDX_W'({addr_ff, bit_ff});
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            // Wait here only while the previous response is still unread.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

endmodule

// File: hw/rtl/bitmap_first_fit_allocator_top.sv
// Top level of the bitmap first-fit allocator: word-count register, sequencer
// and map memory. Depends on bffa_pkg, bffa_if, bffa_map and bffa_ctrl.
//
//   Channel   Dir  Payload                         Handshake
//   req_ch    in   kind[0], position[9:0]          valid/ready
//   rsp_ch    out  status[1:0], entry_index[9:0]   valid/ready
//   csr_ch    in   data[5:0] (words_in_use)        valid/ready, always ready
//
// An allocate reads map words from word 0, one per cycle through the single
// memory read port, until one has a clear bit or the word limit is reached (0 to
// 32 words read). A free rewrites one word; an out-of-range free reads none.
// Requests are accepted one at a time; the response register lets the next
// request start while the last response is still waiting.
// Reset clears the map (per-word valid bits) and sets words_in_use to 32.
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_top
   import bffa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bffa_req_if.sink   req_ch,
   bffa_rsp_if.source rsp_ch,
   bffa_csr_if.sink   csr_ch
);

   logic [CFG_W-1:0]  words_ff;
   logic [CFG_W-1:0]  limit;
   map_req_type       map_req;
   logic [WORD_W-1:0] rd_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= CFG_W'(WORDS_RESET);
      end else if (csr_ch.valid) begin
         words_ff <= csr_ch.data;
      end
   end

   assign csr_ch.ready = 1'b1;

   // A word count above the map size covers the whole map.
   assign limit = (words_ff > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS) : words_ff;

   bffa_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .limit           (limit),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_kind        (req_ch.kind),
      .req_position    (req_ch.position),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_entry_index (rsp_ch.entry_index),
      .map_req         (map_req),
      .rd_word         (rd_word)
   );

   bffa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_word (rd_word)
   );

endmodule
